@@ rtl/core/mnip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mnip_pkg;

  // fixed field widths of the channels
  localparam int ID_BITS   = 5;
  localparam int CONF_BITS = 16;

  // threshold after reset
  localparam logic [CONF_BITS-1:0] THRESH_RESET = 16'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/mnip_count_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mnip_count_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/markov_next_item_predictor_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports                                        Beat
// in       in_valid/in_ready, in_item_id                one item id
// out      out_valid/out_ready, out_predicted_id,       one prediction
//          out_confidence, out_prefetch
// cfg      cfg_we, cfg_wdata                            threshold write
//
// An in-range item goes through these steps after acceptance: its counter is
// read, then written back, then the row scan reads one counter per cycle
// through the single read port of the counter RAM. An out-of-range id
// skips the update and the scan.
// After reset a clearing pass writes zero to the counter RAM, one entry per
// cycle; no item is accepted until it ends.
// A finished result waits in the output register; the block takes the next
// item meanwhile and stalls only when that item's result is ready.

module markov_next_item_predictor_core #(
  parameter int NUM_ITEMS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [mnip_pkg::ID_BITS-1:0]   in_item_id,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [mnip_pkg::ID_BITS-1:0]   out_predicted_id,
  output logic      [mnip_pkg::CONF_BITS-1:0] out_confidence,
  output logic                                out_prefetch,
  input  wire logic                           cfg_we,
  input  wire logic [mnip_pkg::CONF_BITS-1:0] cfg_wdata
);

  import mnip_pkg::*;

  localparam int DEPTH = NUM_ITEMS * NUM_ITEMS;
  localparam int IB    = $clog2(NUM_ITEMS);
  localparam int AW    = $clog2(DEPTH);
  localparam int KB    = $clog2(NUM_ITEMS + 1);
  localparam int CW    = (COUNT_BITS > CONF_BITS) ? COUNT_BITS : CONF_BITS;

  state_t state_r, state_nxt;

  logic [AW-1:0]         clr_r;
  logic [IB-1:0]         prev_r;
  logic [IB-1:0]         cur_r;
  logic [AW-1:0]         cell_r;
  logic [KB-1:0]         k_r;
  logic                  pend_r;
  logic [IB-1:0]         pend_idx_r;
  logic [COUNT_BITS-1:0] best_cnt_r;
  logic [IB-1:0]         best_idx_r;
  logic [CONF_BITS-1:0]  thr_r;
  logic                  out_valid_r;
  logic [ID_BITS-1:0]    out_id_r;
  logic [CONF_BITS-1:0]  out_conf_r;
  logic                  out_pf_r;

  logic                  in_fire;
  logic                  in_range;
  logic [IB-1:0]         in_idx;
  logic                  out_free;
  logic                  scan_last;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [COUNT_BITS-1:0] rd_data;
  logic [CW-1:0]         best_ext;
  logic [CW-1:0]         thr_ext;

  assign in_range  = 32'(in_item_id) < NUM_ITEMS;
  assign in_idx    = IB'(in_item_id);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign scan_last = 32'(k_r) == NUM_ITEMS;
  assign best_ext  = CW'(best_cnt_r);
  assign thr_ext   = CW'(thr_r);

  mnip_count_ram #(
    .DEPTH (DEPTH),
    .WIDTH (COUNT_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (32'(clr_r) == DEPTH - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_range ? ST_UPDATE : ST_FINISH;
        end
      end
      ST_UPDATE: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // RAM access and handshake per state
  always_comb begin
    in_ready = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = cell_r;
    wr_data  = rd_data;
    rd_en    = 1'b0;
    rd_addr  = AW'(cur_r) * AW'(NUM_ITEMS) + AW'(k_r);
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid && in_range;
        rd_addr  = AW'(prev_r) * AW'(NUM_ITEMS) + AW'(in_idx);
      end
      ST_UPDATE: begin
        // saturate at all ones
        wr_en   = 1'b1;
        wr_data = (rd_data == '1) ? rd_data : rd_data + 1'b1;
      end
      ST_SCAN: begin
        rd_en = !scan_last;
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      prev_r      <= '0;
      pend_r      <= 1'b0;
      thr_r       <= THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (in_fire && in_range) begin
        prev_r <= in_idx;
      end
      pend_r <= (state_r == ST_SCAN) && !scan_last;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (state_r == ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_r      <= in_idx;
      cell_r     <= AW'(prev_r) * AW'(NUM_ITEMS) + AW'(in_idx);
      k_r        <= '0;
      best_cnt_r <= '0;
      best_idx_r <= '0;
    end
    if (state_r == ST_SCAN && !scan_last) begin
      k_r        <= k_r + 1'b1;
      pend_idx_r <= IB'(k_r);
    end
    // keep the first strict maximum
    if (pend_r && rd_data > best_cnt_r) begin
      best_cnt_r <= rd_data;
      best_idx_r <= pend_idx_r;
    end
    if (state_r == ST_FINISH && out_free) begin
      out_id_r   <= ID_BITS'(best_idx_r);
      out_conf_r <= best_ext[CONF_BITS-1:0];
      out_pf_r   <= (best_ext > thr_ext) && (best_idx_r != cur_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_predicted_id = out_id_r;
  assign out_confidence   = out_conf_r;
  assign out_prefetch     = out_pf_r;

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import mnip_pkg::*;

  localparam int NUM_ITEMS  = 32;
  localparam int COUNT_BITS = 16;

  typedef struct packed {
    logic [ID_BITS-1:0]   predicted_id;
    logic [CONF_BITS-1:0] confidence;
    logic                 prefetch;
  } prediction_t;

  // Track the transition table and predict each successor
  class transition_scoreboard;
    bit [COUNT_BITS-1:0] pair_counts [NUM_ITEMS*NUM_ITEMS];
    int unsigned         last_id;
    bit [CONF_BITS-1:0]  threshold;
    prediction_t         predictions_due [$];
    int unsigned         fails;

    function new();
      foreach (pair_counts[i]) pair_counts[i] = '0;
      last_id   = 0;
      threshold = THRESH_RESET;
      fails     = 0;
    endfunction

    function int unsigned pending();
      return predictions_due.size();
    endfunction

    // Bump the pair counter, then scan the row of the current id
    function void note_item(logic [ID_BITS-1:0] item_id);
      int unsigned         cur;
      int unsigned         best_idx;
      bit [COUNT_BITS-1:0] best_cnt;
      prediction_t         p;
      cur      = item_id;
      best_idx = 0;
      best_cnt = '0;
      p        = '0;
      if (cur < NUM_ITEMS) begin
        if (last_id < NUM_ITEMS) begin
          if (pair_counts[last_id*NUM_ITEMS + cur] != {COUNT_BITS{1'b1}})
            pair_counts[last_id*NUM_ITEMS + cur]++;
        end
        last_id = cur;
        // strict compare keeps the lowest index on ties
        for (int k = 0; k < NUM_ITEMS; k++) begin
          if (pair_counts[cur*NUM_ITEMS + k] > best_cnt) begin
            best_cnt = pair_counts[cur*NUM_ITEMS + k];
            best_idx = k;
          end
        end
        p.predicted_id = best_idx[ID_BITS-1:0];
        p.confidence   = best_cnt[CONF_BITS-1:0];
        p.prefetch     = (best_cnt > threshold) && (best_idx != cur);
      end
      predictions_due.push_back(p);
    endfunction

    // Compare one output beat against the oldest prediction
    function void check_prediction(logic [ID_BITS-1:0] pred_id,
                                   logic [CONF_BITS-1:0] conf, logic pf);
      prediction_t p;
      if (predictions_due.size() == 0) begin
        $error("unexpected output beat: predicted_id %0d confidence %0d prefetch %0d",
               pred_id, conf, pf);
        fails++;
        return;
      end
      p = predictions_due.pop_front();
      if (pred_id !== p.predicted_id) begin
        $error("predicted_id: expected %0d, got %0d", p.predicted_id, pred_id);
        fails++;
      end
      if (conf !== p.confidence) begin
        $error("confidence: expected %0d, got %0d", p.confidence, conf);
        fails++;
      end
      if (pf !== p.prefetch) begin
        $error("prefetch: expected %0d, got %0d", p.prefetch, pf);
        fails++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [ID_BITS-1:0]   in_item_id = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ID_BITS-1:0]   out_predicted_id;
  logic [CONF_BITS-1:0] out_confidence;
  logic                 out_prefetch;
  logic                 cfg_we = 1'b0;
  logic [CONF_BITS-1:0] cfg_wdata = '0;
  bit                   steady = 1'b0;

  transition_scoreboard sb;

  markov_next_item_predictor_core #(
    .NUM_ITEMS (NUM_ITEMS),
    .COUNT_BITS(COUNT_BITS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_item_id      (in_item_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_predicted_id(out_predicted_id),
    .out_confidence  (out_confidence),
    .out_prefetch    (out_prefetch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Stall the output side at random unless in a steady stretch
  always @(posedge clk) begin
    if (!rst_n)
      out_ready <= 1'b0;
    else
      out_ready <= steady || ($urandom_range(0, 99) >= 22);
  end

  // Check every output beat
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_prediction(out_predicted_id, out_confidence, out_prefetch);
  end

  // Send one item id; hold valid and payload until the beat is taken
  task automatic send_item(input logic [ID_BITS-1:0] item_id);
    if (!steady) begin
      while ($urandom_range(0, 99) < 22) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_item_id <= item_id;
    do @(posedge clk); while (!in_ready);
    sb.note_item(item_id);
  endtask

  // Drop valid and wait until every prediction has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CONF_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.threshold = value;
  endtask

  initial begin
    logic [ID_BITS-1:0]   directed [$];
    logic [ID_BITS-1:0]   pattern [$];
    logic [CONF_BITS-1:0] thresholds [5];
    int unsigned          sent;
    int unsigned          len;
    int unsigned          reps;

    sb = new();
    // empty row, self transition, tie on row 3, then a strong 3->7 pair
    directed = '{5'd5, 5'd31, 5'd0, 5'd0, 5'd0, 5'd3, 5'd7, 5'd3, 5'd2, 5'd3,
                 5'd7, 5'd3, 5'd7, 5'd3, 5'd7, 5'd3, 5'd7, 5'd3, 5'd7, 5'd3,
                 5'd31, 5'd16, 5'd15, 5'd0};
    thresholds[0] = 16'd0;
    thresholds[1] = 16'hFFFF;
    thresholds[2] = 16'd1;
    thresholds[3] = 16'($urandom_range(2, 40));
    thresholds[4] = THRESH_RESET;

    // Hold reset, then wait out the table clearing pass
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!in_ready);

    write_threshold(THRESH_RESET);
    foreach (directed[i]) send_item(directed[i]);
    wait_idle();

    // Random phases: mostly repeated short id patterns, some noise
    for (int ph = 0; ph < 5; ph++) begin
      write_threshold(thresholds[ph]);
      steady = (ph == 2);
      sent = 0;
      while (sent < 390) begin
        if ($urandom_range(0, 99) < 80) begin
          len  = $urandom_range(1, 6);
          reps = $urandom_range(3, 10);
          pattern.delete();
          repeat (len) begin
            if ($urandom_range(0, 1) == 0)
              pattern.push_back(ID_BITS'($urandom_range(0, 7)));
            else
              pattern.push_back(ID_BITS'($urandom_range(0, 31)));
          end
          repeat (reps) begin
            foreach (pattern[i]) begin
              send_item(pattern[i]);
              sent++;
            end
          end
        end else begin
          send_item(ID_BITS'($urandom));
          sent++;
        end
      end
      wait_idle();
      steady = 1'b0;
    end

    repeat (40) @(posedge clk);
    if (sb.fails == 0)
      $display("** markov_next_item_predictor_core: PASSED **");
    else
      $display("** markov_next_item_predictor_core: FAILED **");
    $finish;
  end

  // Stop a hung run
  initial begin
    #8_000_000;
    $display("** markov_next_item_predictor_core: FAILED **");
    $finish;
  end

endmodule
